[hdl/msd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// msd_pkg
// Shared types and constants for the motor stall detector.
// ============================================================================
package msd_pkg;

    // Number of finger lanes in service (1..5)
    localparam int FINGERS = 5;

    localparam int TIME_W   = 32;
    localparam int MASK_W   = 5;
    localparam int DUTY_W   = 8;
    localparam int SPEED_W  = 16;
    localparam int LIMIT_W  = 15;
    localparam int TMO_W    = 16;
    localparam int IDX_W    = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Register indexes on the APB port (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_SPEED_LIMIT = 2'd0,
        REG_TIMEOUT     = 2'd1,
        REG_MIN_DUTY    = 2'd2
    } t_reg_idx;

    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = LIMIT_W'(13);
    localparam logic [TMO_W-1:0]   TIMEOUT_RST     = TMO_W'(500);
    localparam logic [DUTY_W-1:0]  MIN_DUTY_RST    = DUTY_W'(0);

    // Configuration seen by every lane
    typedef struct packed {
        logic [LIMIT_W-1:0] speed_limit;
        logic [TMO_W-1:0]   timeout;
        logic [DUTY_W-1:0]  min_duty;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic             all_ok;
        logic [IDX_W-1:0] stalled_finger;
    } t_result;

endpackage

[hdl/msd_in_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// msd_in_if
// Snapshot channel: timestamp, enable mask, duty and speed of each finger.
// ============================================================================
interface msd_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic [4:0]         enabled_mask;
    logic [7:0]         duty_f0;
    logic [7:0]         duty_f1;
    logic [7:0]         duty_f2;
    logic [7:0]         duty_f3;
    logic [7:0]         duty_f4;
    logic signed [15:0] speed_f0;
    logic signed [15:0] speed_f1;
    logic signed [15:0] speed_f2;
    logic signed [15:0] speed_f3;
    logic signed [15:0] speed_f4;

    modport source (
        output valid, now_ms, enabled_mask,
               duty_f0, duty_f1, duty_f2, duty_f3, duty_f4,
               speed_f0, speed_f1, speed_f2, speed_f3, speed_f4,
        input  ready
    );
    modport sink (
        input  valid, now_ms, enabled_mask,
               duty_f0, duty_f1, duty_f2, duty_f3, duty_f4,
               speed_f0, speed_f1, speed_f2, speed_f3, speed_f4,
        output ready
    );
endinterface

[hdl/msd_out_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// msd_out_if
// Result channel: overall status and lowest faulted finger.
// ============================================================================
interface msd_out_if;
    logic       valid;
    logic       ready;
    logic       all_ok;
    logic [2:0] stalled_finger;

    modport source (output valid, all_ok, stalled_finger, input ready);
    modport sink   (input valid, all_ok, stalled_finger, output ready);
endinterface

[hdl/msd_lane.sv]
`timescale 1ns / 1ps
// ============================================================================
// msd_lane
// One finger: stall qualification, start-time tracking and timeout compare.
// ============================================================================
module msd_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_xfer,
    input  msd_pkg::t_cfg                 i_cfg,
    input  logic [msd_pkg::TIME_W-1:0]    i_now,
    input  logic                          i_enable,
    input  logic [msd_pkg::DUTY_W-1:0]    i_duty,
    input  logic signed [msd_pkg::SPEED_W-1:0] i_speed,
    output logic                          o_fault
);
    import msd_pkg::*;

    logic              r_active;
    logic [TIME_W-1:0] r_since;
    logic [SPEED_W-1:0] w_mag;
    logic              w_stall;
    logic [TIME_W-1:0] w_start;
    logic [TIME_W-1:0] w_elapsed;

    // Magnitude of the signed speed; -32768 maps to 32768
    assign w_mag = i_speed[SPEED_W-1] ? SPEED_W'(-i_speed) : SPEED_W'(i_speed);

    // Driven and not moving
    assign w_stall = i_enable && (i_duty > i_cfg.min_duty)
                   && (w_mag < {1'b0, i_cfg.speed_limit});

    // A stall that starts on this snapshot has zero elapsed time
    assign w_start   = r_active ? r_since : i_now;
    assign w_elapsed = i_now - w_start;
    assign o_fault   = w_stall && (w_elapsed >= {{(TIME_W-TMO_W){1'b0}}, i_cfg.timeout});

    // Start-time record, updated on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_xfer) begin
            r_active <= w_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_xfer && w_stall && !r_active) begin
            r_since <= i_now;
        end
    end

endmodule

[hdl/msd_merge.sv]
`timescale 1ns / 1ps
// ============================================================================
// msd_merge
// Combines lane fault flags into one result: ok, or the lowest faulted finger.
// ============================================================================
module msd_merge (
    input  logic [msd_pkg::FINGERS-1:0] i_fault,
    output msd_pkg::t_result            o_result
);
    import msd_pkg::*;

    // Priority pick, lowest index wins
    always_comb begin
        o_result.all_ok         = 1'b1;
        o_result.stalled_finger = '0;
        for (int f = FINGERS - 1; f >= 0; f--) begin
            if (i_fault[f]) begin
                o_result.all_ok         = 1'b0;
                o_result.stalled_finger = IDX_W'(f);
            end
        end
    end

endmodule

[hdl/motor_stall_detector.sv]
`timescale 1ns / 1ps
// ============================================================================
// motor_stall_detector
// Stall fault detector for up to five finger motors, one result per snapshot.
// ============================================================================
// Each snapshot transfer on i_snap yields one result on o_res. A finger lane
// qualifies the stall (enabled, duty above min_active_duty, speed magnitude
// below stall_speed_limit), keeps its start time and compares the wrapped
// elapsed time against the stall timeout, all in the cycle of the transfer;
// the merge picks the lowest faulted finger. The result is registered in the
// output register, or in a one-entry skid behind it while o_res stalls; the
// skid keeps i_snap ready while a result waits, so one snapshot per cycle is
// sustained while o_res takes results. APB registers sit at byte addresses
// 0x0 (stall_speed_limit), 0x4 (stall timeout) and 0x8 (min_active_duty).
// ============================================================================
module motor_stall_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    msd_in_if.sink                      i_snap,
    msd_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msd_pkg::APB_AW-1:0]  paddr,
    input  logic [msd_pkg::APB_DW-1:0]  pwdata,
    output logic [msd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import msd_pkg::*;

    t_cfg                     r_cfg;
    logic [1:0]               w_reg_idx;
    logic                     w_wr;
    logic                     w_in_xfer;
    logic                     w_out_xfer;
    logic [FINGERS-1:0]       w_fault;
    t_result                  w_result;
    logic                     r_out_valid;
    t_result                  r_out;
    logic                     r_skid_valid;
    t_result                  r_skid;

    logic [4:0][DUTY_W-1:0]         w_duty;
    logic signed [SPEED_W-1:0]      w_speed [5];

    // ------------------------------------------------------------------
    // APB configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit <= SPEED_LIMIT_RST;
            r_cfg.timeout     <= TIMEOUT_RST;
            r_cfg.min_duty    <= MIN_DUTY_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_SPEED_LIMIT: r_cfg.speed_limit <= pwdata[LIMIT_W-1:0];
                REG_TIMEOUT:     r_cfg.timeout     <= pwdata[TMO_W-1:0];
                REG_MIN_DUTY:    r_cfg.min_duty    <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SPEED_LIMIT: prdata = APB_DW'(r_cfg.speed_limit);
            REG_TIMEOUT:     prdata = APB_DW'(r_cfg.timeout);
            REG_MIN_DUTY:    prdata = APB_DW'(r_cfg.min_duty);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign i_snap.ready = !r_skid_valid;
    assign w_in_xfer    = i_snap.valid && i_snap.ready;
    assign w_out_xfer   = r_out_valid && o_res.ready;

    // ------------------------------------------------------------------
    // Finger lanes
    // ------------------------------------------------------------------
    assign w_duty  = {i_snap.duty_f4, i_snap.duty_f3, i_snap.duty_f2,
                      i_snap.duty_f1, i_snap.duty_f0};
    assign w_speed[0] = i_snap.speed_f0;
    assign w_speed[1] = i_snap.speed_f1;
    assign w_speed[2] = i_snap.speed_f2;
    assign w_speed[3] = i_snap.speed_f3;
    assign w_speed[4] = i_snap.speed_f4;

    for (genvar f = 0; f < FINGERS; f++) begin : g_lane
        msd_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_xfer   (w_in_xfer),
            .i_cfg    (r_cfg),
            .i_now    (i_snap.now_ms),
            .i_enable (i_snap.enabled_mask[f]),
            .i_duty   (w_duty[f]),
            .i_speed  (w_speed[f]),
            .o_fault  (w_fault[f])
        );
    end

    // ------------------------------------------------------------------
    // Merge
    // ------------------------------------------------------------------
    msd_merge u_merge (
        .i_fault  (w_fault),
        .o_result (w_result)
    );

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_xfer) begin
            if (!r_out_valid || w_out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out <= r_skid;
            end
        end else if (w_in_xfer) begin
            if (!r_out_valid || w_out_xfer) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.all_ok         = r_out.all_ok;
    assign o_res.stalled_finger = r_out.stalled_finger;

endmodule

[hdl/msd_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// msd_checker
// Port-level checks of the motor stall detector, bound to the top level.
// ============================================================================
module msd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_all_ok,
    input  logic [2:0] i_stalled_finger
);
    import msd_pkg::*;

    // An ok result carries finger zero
    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_all_ok) |-> (i_stalled_finger == 3'd0))
        else $error("all_ok result with nonzero finger");

    // A faulted finger is one of the lanes in service
    a_finger_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_stalled_finger <= IDX_W'(FINGERS - 1)))
        else $error("stalled_finger out of range");

    // Input side only backs up when a result is waiting
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_all_ok) && $stable(i_stalled_finger)))
        else $error("result changed while stalled");

endmodule

bind motor_stall_detector msd_checker u_msd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_snap.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_all_ok         (o_res.all_ok),
    .i_stalled_finger (o_res.stalled_finger)
);
